// ===== rtl/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types, widths, register indexes and the arctangent table of the
// terrain slope pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tse_pkg;

  localparam int DEFAULT_MAX_COLUMNS = 1024;
  localparam int DEFAULT_HEIGHT_BITS = 20;

  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int COLUMNS_BITS = 11;
  localparam logic [CFG_IDX_BITS-1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLUMNS   = 2'd1;
  localparam logic [CFG_BITS-1:0]     CELL_SIZE_RESET = 16'd100;
  localparam logic [COLUMNS_BITS-1:0] COLUMNS_RESET   = 11'd1024;

  localparam int ROW_BITS   = 16;
  localparam int COL_BITS   = 10;
  localparam int ANGLE_BITS = 15;
  localparam int ANGLE_MAX  = 23040;
  localparam int D_BITS     = 17;

  // the largest normalised operand sits in [2^28, 2^29)
  localparam int NORM_BITS = 29;
  localparam int SQ_BITS   = 2 * NORM_BITS + 1;
  localparam int RES_BITS  = SQ_BITS + 1;
  localparam int SQ_STEPS  = (SQ_BITS + 1) / 2;

  localparam int CORDIC_STEPS = 20;
  localparam int XY_BITS      = 34;
  localparam int Z_BITS       = 25;

  typedef struct packed {
    logic                known;
    logic                zero;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
  } tag_t;

  typedef struct packed {
    logic [SQ_BITS-1:0]   rem;
    logic [RES_BITS-1:0]  res;
    logic [NORM_BITS-1:0] d;
    tag_t                 tag;
  } root_t;

  typedef struct packed {
    logic signed [XY_BITS-1:0] x;
    logic signed [XY_BITS-1:0] y;
    logic signed [Z_BITS-1:0]  z;
    tag_t                      tag;
  } rot_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [Z_BITS-1:0] atan_of(input int i);
    logic signed [Z_BITS-1:0] v;
    unique case (i)
      0:  v = 25'sd2949120;
      1:  v = 25'sd1740967;
      2:  v = 25'sd919879;
      3:  v = 25'sd466945;
      4:  v = 25'sd234379;
      5:  v = 25'sd117304;
      6:  v = 25'sd58666;
      7:  v = 25'sd29335;
      8:  v = 25'sd14668;
      9:  v = 25'sd7334;
      10: v = 25'sd3667;
      11: v = 25'sd1833;
      12: v = 25'sd917;
      13: v = 25'sd458;
      14: v = 25'sd229;
      15: v = 25'sd115;
      16: v = 25'sd57;
      17: v = 25'sd29;
      18: v = 25'sd14;
      19: v = 25'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tse_line_store.sv =====
// ----------------------------------------------------------------------------
// tse_line_store
// Raster counters, the two row stores and the per-axis height differences.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_line_store #(
  parameter int MAX_COLUMNS = tse_pkg::DEFAULT_MAX_COLUMNS,
  parameter int HEIGHT_BITS = tse_pkg::DEFAULT_HEIGHT_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire logic                             in_valid,
  input  wire logic                             cmd,
  input  wire logic signed [HEIGHT_BITS-1:0]    height_mm,
  input  wire logic                             height_known,
  input  wire logic                             frame_start,
  input  wire logic [tse_pkg::CFG_BITS-1:0]     cell_size,
  input  wire logic [tse_pkg::COLUMNS_BITS-1:0] columns,
  output logic                                  g_valid,
  output logic signed [HEIGHT_BITS+1:0]         g_sx,
  output logic signed [HEIGHT_BITS+1:0]         g_sy,
  output logic [tse_pkg::D_BITS-1:0]            g_d,
  output tse_pkg::tag_t                         g_tag
);
  import tse_pkg::*;

  localparam int H  = HEIGHT_BITS;
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int IW = $clog2(MAX_COLUMNS);
  localparam int LW = (CW > COLUMNS_BITS) ? CW : COLUMNS_BITS;

  logic acc;
  assign acc = in_valid && en;

  // raster state
  logic [CW-1:0]       column_count, column_count_next;
  logic [ROW_BITS-1:0] row_count, row_count_next;
  logic [1:0]          rows_done, rows_done_next;
  logic                pad_cur, pad_cur_next;
  logic                pad_above, pad_above_next;

  logic [LW-1:0] cols_w;
  logic [CW-1:0] cols;
  logic [CW-1:0] c;
  logic [H:0]    cur;
  logic          produce;
  logic [ROW_BITS-1:0] row_o;

  always_comb begin
    cols_w = LW'(columns);
    if (cols_w == '0) cols_w = LW'(1);
    else if (cols_w > LW'(MAX_COLUMNS)) cols_w = LW'(MAX_COLUMNS);
    cols = CW'(cols_w);
  end

  always_comb begin
    logic [CW-1:0]       cc;
    logic [ROW_BITS-1:0] rc;
    logic [1:0]          rd;
    logic                pc, pa;
    cc = column_count; rc = row_count; rd = rows_done; pc = pad_cur; pa = pad_above;
    if (frame_start) begin
      cc = '0; rc = '0; rd = '0; pc = 1'b0; pa = 1'b0;
    end
    if (cc >= cols) begin
      cc = '0; rc = rc + 1'b1;
      if (rd < 2'd2) rd = rd + 1'b1;
      pa = pc; pc = 1'b0;
    end
    c = cc;
    if (cmd) begin
      cur = '0; pc = 1'b1;
    end else if (height_known) begin
      cur = {1'b1, height_mm};
    end else begin
      cur = '0;
    end
    produce = (rd != 2'd0) && !pa;
    row_o   = rc - 1'b1;
    cc = c + 1'b1;
    if (cc >= cols) begin
      cc = '0; rc = rc + 1'b1;
      if (rd < 2'd2) rd = rd + 1'b1;
      pa = pc; pc = 1'b0;
    end
    column_count_next = cc;
    row_count_next    = rc;
    rows_done_next    = rd;
    pad_cur_next      = pc;
    pad_above_next    = pa;
  end

  // neighbour availability, taken with the beat
  logic has_w, has_e;
  logic [IW-1:0] a_c, a_e;
  logic [CW:0]   c_plus;
  always_comb begin
    c_plus = {1'b0, c} + 1'b1;
    has_w  = (c != '0);
    has_e  = (c_plus < {1'b0, cols});
    a_c    = IW'(c);
    a_e    = IW'(c_plus);
  end

  // rows_done as seen by the sample itself (after any row close before it)
  logic [1:0] rd_seen;
  always_comb begin
    rd_seen = frame_start ? 2'd0 : rows_done;
    if ((frame_start ? '0 : column_count) >= cols && rd_seen < 2'd2)
      rd_seen = rd_seen + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      rows_done    <= '0;
      pad_cur      <= 1'b0;
      pad_above    <= 1'b0;
    end else if (acc) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      rows_done    <= rows_done_next;
      pad_cur      <= pad_cur_next;
      pad_above    <= pad_above_next;
    end
  end

  // row stores: bit H is the known flag
  logic [H:0] above_mem   [MAX_COLUMNS];
  logic [H:0] two_abv_mem [MAX_COLUMNS];
  logic [H:0] rd_c, rd_e, rd_n;

  logic                s1w, s1p;
  logic [IW-1:0]       s1_addr;
  logic [H:0]          s1_cur;
  logic                s1_has_n, s1_has_w, s1_has_e, s1_fwd;
  logic [ROW_BITS-1:0] s1_row;
  logic [COL_BITS-1:0] s1_col;
  logic [H:0]          centre_prev;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_c <= above_mem[a_c];
      rd_e <= above_mem[a_e];
      rd_n <= two_abv_mem[a_c];
      above_mem[a_c] <= cur;
    end
    if (en && s1w) two_abv_mem[s1_addr] <= rd_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1w <= 1'b0;
      s1p <= 1'b0;
    end else if (en) begin
      s1w <= acc;
      s1p <= acc && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1w) centre_prev <= rd_c;
    if (acc) begin
      s1_addr  <= a_c;
      s1_cur   <= cur;
      s1_has_n <= (rd_seen == 2'd2);
      s1_has_w <= has_w;
      s1_has_e <= has_e;
      s1_fwd   <= s1w && (s1_addr == a_c);
      s1_row   <= row_o;
      s1_col   <= COL_BITS'(c);
    end
  end

  // differences of the centre cell
  logic [H:0] north;
  logic signed [H+1:0] hc, hn, hs, hw, he, sx, sy;
  logic nk, sk, wk, ek, ck;
  always_comb begin
    north = s1_fwd ? centre_prev : rd_n;
    hc = (H+2)'(signed'(rd_c[H-1:0]));
    hn = (H+2)'(signed'(north[H-1:0]));
    hs = (H+2)'(signed'(s1_cur[H-1:0]));
    hw = (H+2)'(signed'(centre_prev[H-1:0]));
    he = (H+2)'(signed'(rd_e[H-1:0]));
    ck = rd_c[H];
    nk = s1_has_n && north[H];
    sk = s1_cur[H];
    wk = s1_has_w && centre_prev[H];
    ek = s1_has_e && rd_e[H];
    sy = (nk ? hc - hn : '0) + (sk ? hs - hc : '0);
    sx = (wk ? hc - hw : '0) + (ek ? he - hc : '0);
    if (nk ^ sk) sy = sy <<< 1;
    if (wk ^ ek) sx = sx <<< 1;
  end

  always_ff @(posedge clk) begin
    if (rst) g_valid <= 1'b0;
    else if (en) g_valid <= s1p;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_sx <= sx;
      g_sy <= sy;
      g_d  <= {((cell_size == '0) ? CFG_BITS'(1) : cell_size), 1'b0};
      g_tag.known <= ck;
      g_tag.zero  <= !ck || (sx == '0 && sy == '0);
      g_tag.row   <= s1_row;
      g_tag.col   <= s1_col;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tse_norm.sv =====
// ----------------------------------------------------------------------------
// tse_norm
// Magnitudes, scaling of the largest into [2^28, 2^29), squares and their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_norm #(
  parameter int HEIGHT_BITS = tse_pkg::DEFAULT_HEIGHT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          g_valid,
  input  wire logic signed [HEIGHT_BITS+1:0] g_sx,
  input  wire logic signed [HEIGHT_BITS+1:0] g_sy,
  input  wire logic [tse_pkg::D_BITS-1:0]    g_d,
  input  wire tse_pkg::tag_t                 g_tag,
  output logic                               n_valid,
  output tse_pkg::root_t                     n_out
);
  import tse_pkg::*;

  localparam int GW = HEIGHT_BITS + 2;
  localparam int AW = (GW > D_BITS) ? GW : D_BITS;
  localparam int PW = $clog2(AW);
  localparam int WW = AW + NORM_BITS;

  logic [3:0] v;

  // stage 1: magnitudes and the largest
  logic [AW-1:0] ax1, ay1, d1, m1;
  tag_t t1;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [AW-1:0] ax, ay, dd, m;
      ax = AW'(g_sx < 0 ? GW'(-g_sx) : GW'(g_sx));
      ay = AW'(g_sy < 0 ? GW'(-g_sy) : GW'(g_sy));
      dd = AW'(g_d);
      m  = (ax > ay) ? ax : ay;
      if (dd > m) m = dd;
      ax1 <= ax; ay1 <= ay; d1 <= dd; m1 <= m; t1 <= g_tag;
    end
  end

  // stage 2: leading one
  logic [AW-1:0] ax2, ay2, d2;
  logic [PW-1:0] msb2;
  tag_t t2;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [PW-1:0] p;
      p = '0;
      for (int i = 0; i < AW; i++) if (m1[i]) p = PW'(i);
      ax2 <= ax1; ay2 <= ay1; d2 <= d1; msb2 <= p; t2 <= t1;
    end
  end

  // stage 3: scale
  logic [NORM_BITS-1:0] ax3, ay3, d3;
  tag_t t3;
  function automatic logic [NORM_BITS-1:0] scale(input logic [AW-1:0] val,
                                                 input logic [PW-1:0] p);
    logic [WW-1:0] w;
    w = WW'(val);
    if (p >= PW'(NORM_BITS - 1)) w = w >> (p - PW'(NORM_BITS - 1));
    else w = w << (PW'(NORM_BITS - 1) - p);
    return w[NORM_BITS-1:0];
  endfunction
  always_ff @(posedge clk) begin
    if (en) begin
      ax3 <= scale(ax2, msb2);
      ay3 <= scale(ay2, msb2);
      d3  <= scale(d2, msb2);
      t3  <= t2;
    end
  end

  // stage 4: squares
  logic [2*NORM_BITS-1:0] qx4, qy4;
  logic [NORM_BITS-1:0]   d4;
  tag_t t4;
  always_ff @(posedge clk) begin
    if (en) begin
      qx4 <= ax3 * ax3;
      qy4 <= ay3 * ay3;
      d4  <= d3;
      t4  <= t3;
    end
  end

  // stage 5: sum into the root chain
  always_ff @(posedge clk) begin
    if (en) begin
      n_out.rem <= SQ_BITS'(qx4) + SQ_BITS'(qy4);
      n_out.res <= '0;
      n_out.d   <= d4;
      n_out.tag <= t4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (en) v <= {v[2:0], g_valid};
  end
  always_ff @(posedge clk) begin
    if (rst) n_valid <= 1'b0;
    else if (en) n_valid <= v[3];
  end

endmodule

`default_nettype wire

// ===== rtl/tse_root_cell.sv =====
// ----------------------------------------------------------------------------
// tse_root_cell
// One result bit of the integer square root (restoring, two bits a cell).
// ----------------------------------------------------------------------------
`default_nettype none

module tse_root_cell #(
  parameter int STEP = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           a_valid,
  input  wire tse_pkg::root_t a,
  output logic                b_valid,
  output tse_pkg::root_t      b
);
  import tse_pkg::*;

  localparam int SH = SQ_BITS - 1 - 2 * STEP;

  root_t nx;
  always_comb begin
    logic [RES_BITS-1:0] bitv, trial;
    bitv  = RES_BITS'(1) << SH;
    trial = a.res + bitv;
    nx    = a;
    if ({1'b0, a.rem} >= trial) begin
      nx.rem = a.rem - trial[SQ_BITS-1:0];
      nx.res = (a.res >> 1) + bitv;
    end else begin
      nx.res = a.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (en) b_valid <= a_valid;
  end
  always_ff @(posedge clk) begin
    if (en) b <= nx;
  end

endmodule

`default_nettype wire

// ===== rtl/tse_rot_cell.sv =====
// ----------------------------------------------------------------------------
// tse_rot_cell
// One vectoring rotation of the arctangent chain.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_rot_cell #(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          a_valid,
  input  wire tse_pkg::rot_t a,
  output logic               b_valid,
  output tse_pkg::rot_t      b
);
  import tse_pkg::*;

  rot_t nx;
  always_comb begin
    logic signed [XY_BITS-1:0] x, y, xs, ys;
    logic signed [Z_BITS-1:0]  z;
    x  = a.x;
    y  = a.y;
    z  = a.z;
    xs = x >>> STEP;
    ys = y >>> STEP;
    nx = a;
    if (y >= 0) begin
      nx.x = x + ys; nx.y = y - xs; nx.z = z + atan_of(STEP);
    end else begin
      nx.x = x - ys; nx.y = y + xs; nx.z = z - atan_of(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (en) b_valid <= a_valid;
  end
  always_ff @(posedge clk) begin
    if (en) b <= nx;
  end

endmodule

`default_nettype wire

// ===== rtl/terrain_slope_from_elevation.sv =====
// ----------------------------------------------------------------------------
// terrain_slope_from_elevation
// Slope angle of each grid cell from a row-major stream of height samples.
// ----------------------------------------------------------------------------
// Use: height samples enter one beat per clock on the in_ channel (valid and
// stall). The beat carrying row r, column c gives the slope of cell (r-1, c)
// on the out_ channel, or no result on the first row of a map and for a row
// that held padding. Padding beats (cmd high) close the last row.
// Throughput: one beat per clock, sustained, while out_stall is low.
// Pipeline: two registers for the row store read and differences, five for
// scaling and squaring, 30 square root cells, 20 arctangent cells and the
// output register.
// The whole pipeline moves on one enable; when the receiver stalls a valid
// result, every stage holds and in_stall rises in the same cycle, so no beat
// is lost. Synchronous reset clears the raster counters and all stage valid
// flags; the row stores are not cleared (reads of unwritten entries never
// reach a result). Configuration writes go through cfg_we / cfg_index /
// cfg_data; the user must make them while the block is idle (unchecked).
// ----------------------------------------------------------------------------
`default_nettype none

module terrain_slope_from_elevation #(
  parameter int MAX_COLUMNS = tse_pkg::DEFAULT_MAX_COLUMNS,
  parameter int HEIGHT_BITS = tse_pkg::DEFAULT_HEIGHT_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tse_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [tse_pkg::CFG_BITS-1:0]     cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             cmd,
  input  wire logic signed [HEIGHT_BITS-1:0]    height_mm,
  input  wire logic                             height_known,
  input  wire logic                             frame_start,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [tse_pkg::ANGLE_BITS-1:0]        slope_angle,
  output logic                                  slope_known,
  output logic [tse_pkg::ROW_BITS-1:0]          cell_row,
  output logic [tse_pkg::COL_BITS-1:0]          cell_column
);
  import tse_pkg::*;

  // configuration registers
  logic [CFG_BITS-1:0]     cell_size_mm;
  logic [COLUMNS_BITS-1:0] columns_in_use;
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size_mm   <= CELL_SIZE_RESET;
      columns_in_use <= COLUMNS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_SIZE: cell_size_mm   <= cfg_data;
        REG_COLUMNS:   columns_in_use <= cfg_data[COLUMNS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // one enable for the whole pipe: hold while a result waits on a stall
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // row stores and differences
  logic                          g_valid;
  logic signed [HEIGHT_BITS+1:0] g_sx, g_sy;
  logic [D_BITS-1:0]             g_d;
  tag_t                          g_tag;

  tse_line_store #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_line (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (in_valid),
    .cmd          (cmd),
    .height_mm    (height_mm),
    .height_known (height_known),
    .frame_start  (frame_start),
    .cell_size    (cell_size_mm),
    .columns      (columns_in_use),
    .g_valid      (g_valid),
    .g_sx         (g_sx),
    .g_sy         (g_sy),
    .g_d          (g_d),
    .g_tag        (g_tag)
  );

  // scaling, squares and sum
  logic  root_v [SQ_STEPS+1];
  root_t root_d [SQ_STEPS+1];

  tse_norm #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .g_valid (g_valid),
    .g_sx    (g_sx),
    .g_sy    (g_sy),
    .g_d     (g_d),
    .g_tag   (g_tag),
    .n_valid (root_v[0]),
    .n_out   (root_d[0])
  );

  // square root: one result bit per cell
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_root
    tse_root_cell #(.STEP(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .a_valid (root_v[i]),
      .a       (root_d[i]),
      .b_valid (root_v[i+1]),
      .b       (root_d[i+1])
    );
  end

  // arctangent of root / d by vectoring rotations
  logic rot_v [CORDIC_STEPS+1];
  rot_t rot_d [CORDIC_STEPS+1];

  always_comb begin
    rot_v[0]     = root_v[SQ_STEPS];
    rot_d[0].x   = XY_BITS'(root_d[SQ_STEPS].d);
    rot_d[0].y   = XY_BITS'(root_d[SQ_STEPS].res);
    rot_d[0].z   = '0;
    rot_d[0].tag = root_d[SQ_STEPS].tag;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    tse_rot_cell #(.STEP(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .a_valid (rot_v[i]),
      .a       (rot_d[i]),
      .b_valid (rot_v[i+1]),
      .b       (rot_d[i+1])
    );
  end

  // round 1/65536 degree to 1/256 degree, clamp to [0, 90] degrees; zero flag gives 0
  logic [ANGLE_BITS-1:0] angle;
  always_comb begin
    logic signed [Z_BITS-1:0] z;
    logic [Z_BITS-1:0]        zp, zr;
    z  = rot_d[CORDIC_STEPS].z;
    zp = (z < 0) ? '0 : Z_BITS'(z);
    zr = (zp + Z_BITS'(128)) >> 8;
    if (rot_d[CORDIC_STEPS].tag.zero) angle = '0;
    else if (zr > Z_BITS'(ANGLE_MAX)) angle = ANGLE_BITS'(ANGLE_MAX);
    else angle = zr[ANGLE_BITS-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= rot_v[CORDIC_STEPS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      slope_angle <= angle;
      slope_known <= rot_d[CORDIC_STEPS].tag.known;
      cell_row    <= rot_d[CORDIC_STEPS].tag.row;
      cell_column <= rot_d[CORDIC_STEPS].tag.col;
    end
  end

  // checks
  a_unknown_flat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !slope_known |-> slope_angle == '0)
    else $error("unknown centre with non-zero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> slope_angle <= ANGLE_BITS'(ANGLE_MAX))
    else $error("slope angle above ninety degrees");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat straight after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall ##1 (out_valid && $stable(cell_column)))
    else $error("pipe moved under a stalled result");

endmodule

`default_nettype wire
